// ===== sv/rbsi_pkg.sv =====
package rbsi_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_AXES      = 3;
	localparam int CFG_IDX_W     = 3;
	// bound minus origin, kept exact
	localparam int DIFF_W        = DATA_W + 1;
	localparam int PROD_W        = DIFF_W + DATA_W;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	typedef struct packed {
		logic signed [DATA_W-1:0] origin_x;
		logic signed [DATA_W-1:0] origin_y;
		logic signed [DATA_W-1:0] origin_z;
		logic signed [DATA_W-1:0] inv_dir_x;
		logic signed [DATA_W-1:0] inv_dir_y;
		logic signed [DATA_W-1:0] inv_dir_z;
		logic signed [DATA_W-1:0] t_low;
		logic signed [DATA_W-1:0] t_high;
	} in_word_t;

	typedef struct packed {
		logic                     hit_flag;
		logic signed [DATA_W-1:0] hit_t;
	} out_word_t;

	// enables of the three register stages inside a slab unit
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} slab_en_t;

endpackage

// ===== sv/ray_box_slab_intersect.sv =====
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | in_word  (origin, inv_dir, t_low, t_high)
// out     | out | out_valid/out_stall | out_word (hit_flag, hit_t)
// cfg     | in  | cfg_we              | cfg_index, cfg_data (box bounds)
//
// one word per cycle while out_stall does not hold the pipeline; five register stages, the last drives out_valid
// stages: diff, multiply, shift and clamp, overlap x/y, overlap z and interval
// each stage advances when it is empty or the next one advances, so bubbles close up
// arst_n clears the valid bits and the box registers to zero
// in_stall rises only when stage one holds a word that cannot move on
module ray_box_slab_intersect import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	logic signed [DATA_W-1:0] box_min_q [NUM_AXES];
	logic signed [DATA_W-1:0] box_max_q [NUM_AXES];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	slab_en_t slab_en;

	logic signed [DATA_W-1:0] org  [NUM_AXES];
	logic signed [DATA_W-1:0] inv  [NUM_AXES];
	logic signed [DATA_W-1:0] near_d [NUM_AXES];
	logic signed [DATA_W-1:0] far_d  [NUM_AXES];

	logic signed [DATA_W-1:0] tlo_s1, tlo_s2, tlo_s3, tlo_s4;
	logic signed [DATA_W-1:0] thi_s1, thi_s2, thi_s3, thi_s4;

	logic                     ok_s4;
	logic signed [DATA_W-1:0] near_s4, far_s4, near2_s4, far2_s4;
	out_word_t                res_s5;

	logic                     ok01;
	logic                     ok2;
	logic signed [DATA_W-1:0] near_f, far_f, t_sel;
	logic                     hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables
	always_comb begin
		en5 = !v_s5 || !out_stall;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
		slab_en.s1 = en1;
		slab_en.s2 = en2;
		slab_en.s3 = en3;
	end

	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign org[0] = in_word.origin_x;
	assign org[1] = in_word.origin_y;
	assign org[2] = in_word.origin_z;
	assign inv[0] = in_word.inv_dir_x;
	assign inv[1] = in_word.inv_dir_y;
	assign inv[2] = in_word.inv_dir_z;

	// negative reciprocal swaps near and far bound; zero counts as positive
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		logic signed [DATA_W-1:0] near_bound, far_bound;

		assign near_bound = inv[a][DATA_W-1] ? box_max_q[a] : box_min_q[a];
		assign far_bound  = inv[a][DATA_W-1] ? box_min_q[a] : box_max_q[a];

		rbsi_slab #(.FRAC_BITS(FRAC_BITS)) u_near (
			.clk    (clk),
			.en     (slab_en),
			.bound  (near_bound),
			.org    (org[a]),
			.inv    (inv[a]),
			.t_slab (near_d[a])
		);

		rbsi_slab #(.FRAC_BITS(FRAC_BITS)) u_far (
			.clk    (clk),
			.en     (slab_en),
			.bound  (far_bound),
			.org    (org[a]),
			.inv    (inv[a]),
			.t_slab (far_d[a])
		);
	end

	// interval bounds ride along with the slab units
	always_ff @(posedge clk) begin
		if (en1) begin
			tlo_s1 <= in_word.t_low;
			thi_s1 <= in_word.t_high;
		end
		if (en2) begin
			tlo_s2 <= tlo_s1;
			thi_s2 <= thi_s1;
		end
		if (en3) begin
			tlo_s3 <= tlo_s2;
			thi_s3 <= thi_s2;
		end
		if (en4) begin
			tlo_s4 <= tlo_s3;
			thi_s4 <= thi_s3;
		end
	end

	// x and y overlap
	assign ok01 = !((near_d[0] > far_d[1]) || (near_d[1] > far_d[0]));

	always_ff @(posedge clk) begin
		if (en4) begin
			ok_s4    <= ok01;
			near_s4  <= (near_d[1] > near_d[0]) ? near_d[1] : near_d[0];
			far_s4   <= (far_d[1] < far_d[0]) ? far_d[1] : far_d[0];
			near2_s4 <= near_d[2];
			far2_s4  <= far_d[2];
		end
	end

	// z overlap, fall back to far when near is not positive, interval test
	always_comb begin
		ok2    = !((near_s4 > far2_s4) || (near2_s4 > far_s4));
		near_f = (near2_s4 > near_s4) ? near2_s4 : near_s4;
		far_f  = (far2_s4 < far_s4) ? far2_s4 : far_s4;
		t_sel  = (near_f > 0) ? near_f : far_f;
		hit    = ok_s4 && ok2 && !t_sel[DATA_W-1] && (t_sel >= tlo_s4) && (t_sel <= thi_s4);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			res_s5.hit_flag <= hit;
			res_s5.hit_t    <= hit ? t_sel : '0;
		end
	end

	assign out_valid = v_s5;
	assign out_word  = res_s5;

	a_miss_zero_t: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.hit_flag) |-> (out_word.hit_t == '0))
		else $error("miss word carries nonzero distance");

	a_hit_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.hit_flag) |-> !out_word.hit_t[DATA_W-1])
		else $error("hit with negative distance");

	a_xy_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en5 && !ok_s4) |=> (out_valid && !out_word.hit_flag))
		else $error("x/y reject did not reach output as miss");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall))
		else $error("input stalled with a free stage");

endmodule

// ===== sv/rbsi_slab.sv =====
module rbsi_slab import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  slab_en_t                 en,
	input  logic signed [DATA_W-1:0] bound,
	input  logic signed [DATA_W-1:0] org,
	input  logic signed [DATA_W-1:0] inv,
	output logic signed [DATA_W-1:0] t_slab
);

	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [DATA_W-1:0] inv_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] quot;
	logic signed [DATA_W-1:0] t_slab_s3;
	logic                     in_range;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_s1 <= DIFF_W'(bound) - DIFF_W'(org);
			inv_s1  <= inv;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_W'(diff_s1) * PROD_W'(inv_s1);
		end
	end

	// floor shift, then clamp to the 32-bit range
	always_comb begin
		quot     = prod_s2 >>> FRAC_BITS;
		in_range = (quot[PROD_W-1:DATA_W-1] == '0) || (quot[PROD_W-1:DATA_W-1] == '1);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (in_range) begin
				t_slab_s3 <= quot[DATA_W-1:0];
			end else if (quot[PROD_W-1]) begin
				t_slab_s3 <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				t_slab_s3 <= {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
	end

	assign t_slab = t_slab_s3;

endmodule
